FILE: rtl/bba_pkg.sv
// Shared types and codes of the buddy block allocator.
// Depends on nothing; bba_front, bba_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int REQ_SIZE_W = 21;
    localparam int ADDR_W     = 20;
    localparam int FREE_W     = 21;
    localparam int STATUS_W   = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAILED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_FIND,
        B_U_RD,
        B_U_CHK,
        B_SPLIT,
        B_A_DONE,
        B_F_RD,
        B_F_CHK,
        B_M_RD,
        B_M_CHK,
        B_PUSH
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                        clk,
    input  wire                                        we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                           wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bba_front.sv
// Request front end: takes a transaction, rounds the allocate size and
// checks the free address, then hands a classified item to the queue. Uses bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_front import bba_pkg::*; #(
    parameter int HEAP_BYTES      = 1048576,
    parameter int MIN_BLOCK_BYTES = 512,
    parameter int HEADER_BYTES    = 24,
    parameter int ALIGN_BYTES     = 8,
    localparam int NUM_SLOTS = HEAP_BYTES / MIN_BLOCK_BYTES,
    localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1,
    localparam int TOP_ORDER = $clog2(NUM_SLOTS + 1) - 1,
    localparam int ORDERS    = TOP_ORDER + 1,
    localparam int ORD_W     = ORDERS > 1 ? $clog2(ORDERS) : 1,
    localparam int ITEM_W    = 2 + ORD_W + SLOT_W
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire                    clearing,
    input  wire                    req_type,
    input  wire  [REQ_SIZE_W-1:0]  req_size,
    input  wire  [ADDR_W-1:0]      block_addr,
    input  wire                    q_full,
    output logic                   busy,
    output logic                   push,
    output logic [ITEM_W-1:0]      item
);

    localparam int T_W     = 22;
    localparam int A_SH    = T_W + $clog2(ALIGN_BYTES);
    localparam logic [T_W+1:0] A_RECIP =
        (T_W + 2)'(((64'd1 << A_SH) + 64'(ALIGN_BYTES) - 64'd1) / ALIGN_BYTES);
    localparam int F_SH    = ADDR_W + $clog2(MIN_BLOCK_BYTES);
    localparam logic [ADDR_W+1:0] F_RECIP =
        (ADDR_W + 2)'(((64'd1 << F_SH) + 64'(MIN_BLOCK_BYTES) - 64'd1) / MIN_BLOCK_BYTES);
    localparam int CHK_W   = ADDR_W + 17;

    logic                sv_reg,   sv_next;
    logic                type_reg, type_next;
    logic                nz_reg,   nz_next;
    logic                ge_reg,   ge_next;
    logic [ADDR_W-1:0]   off_reg,  off_next;
    logic [T_W-1:0]      qa_reg,   qa_next;
    logic [ADDR_W-1:0]   qf_reg,   qf_next;

    logic                accept;
    logic [T_W-1:0]      total;
    logic [2*T_W+1:0]    prod_a;
    logic [ADDR_W-1:0]   off;
    logic [2*ADDR_W+1:0] prod_f;
    logic [ORDERS-1:0]   fits;
    logic [ORD_W-1:0]    kmin;
    logic                ok_alloc;
    logic                ok_free;
    logic [CHK_W-1:0]    back_mul;

    assign busy   = sv_reg | clearing;
    assign accept = start & ~busy;

    // Rounded size as a count of alignment units, by reciprocal multiply.
    always_comb
    begin
        total   = T_W'(req_size) + T_W'(HEADER_BYTES) + T_W'(ALIGN_BYTES - 1);
        prod_a  = (2 * T_W + 2)'(total) * (2 * T_W + 2)'(A_RECIP);
        off     = block_addr - ADDR_W'(HEADER_BYTES);
        prod_f  = (2 * ADDR_W + 2)'(off) * (2 * ADDR_W + 2)'(F_RECIP);
    end

    always_comb
    begin
        sv_next   = sv_reg;
        type_next = type_reg;
        nz_next   = nz_reg;
        ge_next   = ge_reg;
        off_next  = off_reg;
        qa_next   = qa_reg;
        qf_next   = qf_reg;
        if (accept)
        begin
            sv_next   = 1'b1;
            type_next = req_type;
            nz_next   = req_size != '0;
            ge_next   = block_addr >= ADDR_W'(HEADER_BYTES);
            off_next  = off;
            qa_next   = T_W'(prod_a >> A_SH);
            qf_next   = ADDR_W'(prod_f >> F_SH);
        end
        else if (push)
        begin
            sv_next = 1'b0;
        end
    end

    // Smallest order whose block holds the rounded request.
    always_comb
    begin
        for (int k = 0; k < ORDERS; k++)
        begin
            fits[k] = 64'(qa_reg) <= ((64'(MIN_BLOCK_BYTES) << k) / ALIGN_BYTES);
        end
        kmin = '0;
        for (int k = ORDERS - 1; k >= 0; k--)
        begin
            if (fits[k])
            begin
                kmin = ORD_W'(k);
            end
        end
        ok_alloc = nz_reg & (|fits);
        back_mul = CHK_W'(qf_reg) * CHK_W'(MIN_BLOCK_BYTES);
        ok_free  = ge_reg && (back_mul == CHK_W'(off_reg))
                   && (64'(qf_reg) < 64'(NUM_SLOTS));
    end

    assign push = sv_reg & ~q_full;
    assign item = {type_reg == REQ_FREE,
                   (type_reg == REQ_FREE) ? ok_free : ok_alloc,
                   kmin,
                   SLOT_W'(qf_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else
        begin
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        nz_reg   <= nz_next;
        ge_reg   <= ge_next;
        off_reg  <= off_next;
        qa_reg   <= qa_next;
        qf_reg   <= qf_next;
    end

endmodule

`default_nettype wire

FILE: rtl/bba_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bba_queue #(
    parameter int WIDTH = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire  [WIDTH-1:0] wdata,
    input  wire              pop,
    output logic             valid,
    output logic             full,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ent_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       cnt_reg,  cnt_next;

    assign valid = cnt_reg != 2'd0;
    assign full  = cnt_reg == 2'd2;
    assign rdata = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bba_back.sv
// Back end: order lists, split and merge sequencer, slot memories.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none

module bba_back import bba_pkg::*; #(
    parameter int HEAP_BYTES      = 1048576,
    parameter int MIN_BLOCK_BYTES = 512,
    parameter int HEADER_BYTES    = 24,
    localparam int NUM_SLOTS = HEAP_BYTES / MIN_BLOCK_BYTES,
    localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1,
    localparam int TOP_ORDER = $clog2(NUM_SLOTS + 1) - 1,
    localparam int ORDERS    = TOP_ORDER + 1,
    localparam int ORD_W     = ORDERS > 1 ? $clog2(ORDERS) : 1,
    localparam int ITEM_W    = 2 + ORD_W + SLOT_W
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    input  wire  [ITEM_W-1:0]     q_item,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  done,
    output logic [ADDR_W-1:0]     result_addr,
    output logic [STATUS_W-1:0]   status,
    output logic [FREE_W-1:0]     free_bytes
);

    localparam int FC_W  = $clog2(HEAP_BYTES + 1);
    localparam int LEN_W = SLOT_W + 1;
    localparam int MW    = ORD_W + 2;
    localparam int AM_W  = SLOT_W + 17;

    back_state_t st_reg, st_next;

    logic [SLOT_W-1:0]   s_reg,     s_next;
    logic [SLOT_W-1:0]   b_reg,     b_next;
    logic [SLOT_W-1:0]   cur_reg,   cur_next;
    logic [SLOT_W-1:0]   prev_reg,  prev_next;
    logic [ORD_W-1:0]    k_reg,     k_next;
    logic [ORD_W-1:0]    kmin_reg,  kmin_next;
    logic                first_reg, first_next;
    logic                ret_alloc_reg, ret_alloc_next;
    logic [SLOT_W-1:0]   clr_reg,   clr_next;
    logic [FC_W-1:0]     fc_reg,    fc_next;
    logic [SLOT_W-1:0]   head_reg [ORDERS];
    logic [SLOT_W-1:0]   head_next [ORDERS];
    logic [LEN_W-1:0]    len_reg [ORDERS];
    logic [LEN_W-1:0]    len_next [ORDERS];
    logic                done_reg,  done_next;
    logic [ADDR_W-1:0]   addr_reg,  addr_next;
    logic [STATUS_W-1:0] stat_reg,  stat_next;

    logic                n_we;
    logic [SLOT_W-1:0]   n_waddr;
    logic [SLOT_W-1:0]   n_wdata;
    logic [SLOT_W-1:0]   n_rdata;
    logic                m_we;
    logic [SLOT_W-1:0]   m_waddr;
    logic [MW-1:0]       m_wdata;
    logic [SLOT_W-1:0]   m_raddr;
    logic [MW-1:0]       m_rdata;

    logic                it_free;
    logic                it_ok;
    logic [ORD_W-1:0]    it_kmin;
    logic [SLOT_W-1:0]   it_slot;
    logic                find_any;
    logic [ORD_W-1:0]    find_k;
    logic                cur_hit;
    logic [SLOT_W-1:0]   buddy;
    logic                buddy_free;
    logic [ORD_W-1:0]    k_dec;
    logic [FC_W-1:0]     blk_bytes;
    logic [AM_W-1:0]     addr_wide;
    logic [63:0]         fc_wide;

    assign it_free = q_item[ITEM_W-1];
    assign it_ok   = q_item[ITEM_W-2];
    assign it_kmin = q_item[SLOT_W+ORD_W-1:SLOT_W];
    assign it_slot = q_item[SLOT_W-1:0];

    // Next-free links, one per slot; only entries that were pushed get read.
    bba_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (cur_reg),
        .rdata (n_rdata)
    );

    // Per-slot flags: {free, allocated, order}.
    bba_ram #(.WIDTH(MW), .DEPTH(NUM_SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    always_comb
    begin
        find_any = 1'b0;
        find_k   = '0;
        for (int k = ORDERS - 1; k >= 0; k--)
        begin
            if ((ORD_W'(k) >= kmin_reg) && (len_reg[k] != '0))
            begin
                find_any = 1'b1;
                find_k   = ORD_W'(k);
            end
        end
        cur_hit    = cur_reg == b_reg;
        buddy      = s_reg ^ (SLOT_W'(1) << k_reg);
        buddy_free = m_rdata[MW-1] && (m_rdata[ORD_W-1:0] == k_reg);
        k_dec      = k_reg - ORD_W'(1);
        blk_bytes  = FC_W'(64'(MIN_BLOCK_BYTES) << k_reg);
        addr_wide  = AM_W'(s_reg) * AM_W'(MIN_BLOCK_BYTES) + AM_W'(HEADER_BYTES);
        m_raddr    = (st_reg == B_M_RD) ? buddy : s_reg;
    end

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            B_CLEAR:
            begin
                if (clr_reg == SLOT_W'(NUM_SLOTS - 1))
                begin
                    st_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && it_ok)
                begin
                    st_next = it_free ? B_F_RD : B_FIND;
                end
            end
            B_FIND:
            begin
                st_next = find_any ? B_U_RD : B_IDLE;
            end
            B_U_RD:
            begin
                st_next = B_U_CHK;
            end
            B_U_CHK:
            begin
                if (!cur_hit)
                begin
                    st_next = B_U_RD;
                end
                else
                begin
                    st_next = ret_alloc_reg ? B_SPLIT : B_M_RD;
                end
            end
            B_SPLIT:
            begin
                if (k_reg <= kmin_reg)
                begin
                    st_next = B_A_DONE;
                end
            end
            B_A_DONE:
            begin
                st_next = B_IDLE;
            end
            B_F_RD:
            begin
                st_next = B_F_CHK;
            end
            B_F_CHK:
            begin
                st_next = m_rdata[MW-2] ? B_M_RD : B_IDLE;
            end
            B_M_RD:
            begin
                st_next = (32'(k_reg) < TOP_ORDER) ? B_M_CHK : B_PUSH;
            end
            B_M_CHK:
            begin
                st_next = buddy_free ? B_U_RD : B_PUSH;
            end
            B_PUSH:
            begin
                st_next = B_IDLE;
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        s_next         = s_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        k_next         = k_reg;
        kmin_next      = kmin_reg;
        first_next     = first_reg;
        ret_alloc_next = ret_alloc_reg;
        clr_next       = clr_reg;
        fc_next        = fc_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        done_next      = 1'b0;
        addr_next      = addr_reg;
        stat_next      = stat_reg;
        q_pop          = 1'b0;
        n_we           = 1'b0;
        n_waddr        = s_reg;
        n_wdata        = head_reg[k_reg];
        m_we           = 1'b0;
        m_waddr        = s_reg;
        m_wdata        = {1'b0, 1'b0, k_reg};

        case (st_reg)
            B_CLEAR:
            begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = (clr_reg == '0) ? {1'b1, 1'b0, ORD_W'(TOP_ORDER)} : '0;
                clr_next = clr_reg + SLOT_W'(1);
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    s_next    = it_slot;
                    kmin_next = it_kmin;
                    if (!it_ok)
                    begin
                        done_next = 1'b1;
                        addr_next = '0;
                        stat_next = it_free ? STATUS_BAD_FREE : STATUS_FAILED;
                    end
                end
            end
            B_FIND:
            begin
                if (find_any)
                begin
                    k_next         = find_k;
                    b_next         = head_reg[find_k];
                    cur_next       = head_reg[find_k];
                    first_next     = 1'b1;
                    ret_alloc_next = 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    stat_next = STATUS_FAILED;
                end
            end
            B_U_CHK:
            begin
                if (cur_hit)
                begin
                    // Drop the block from its list: fix the head or the predecessor.
                    if (first_reg)
                    begin
                        head_next[k_reg] = n_rdata;
                    end
                    else
                    begin
                        n_we    = 1'b1;
                        n_waddr = prev_reg;
                        n_wdata = n_rdata;
                    end
                    len_next[k_reg] = len_reg[k_reg] - LEN_W'(1);
                    m_we    = 1'b1;
                    m_waddr = b_reg;
                    m_wdata = {1'b0, 1'b0, k_reg};
                    if (ret_alloc_reg)
                    begin
                        s_next = b_reg;
                    end
                    else
                    begin
                        s_next = (b_reg < s_reg) ? b_reg : s_reg;
                        k_next = k_reg + ORD_W'(1);
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = n_rdata;
                    first_next = 1'b0;
                end
            end
            B_SPLIT:
            begin
                if (k_reg > kmin_reg)
                begin
                    // Push the right half onto the list one order down.
                    n_we    = 1'b1;
                    n_waddr = s_reg + (SLOT_W'(1) << k_dec);
                    n_wdata = head_reg[k_dec];
                    head_next[k_dec] = s_reg + (SLOT_W'(1) << k_dec);
                    len_next[k_dec]  = len_reg[k_dec] + LEN_W'(1);
                    m_we    = 1'b1;
                    m_waddr = s_reg + (SLOT_W'(1) << k_dec);
                    m_wdata = {1'b1, 1'b0, k_dec};
                    k_next  = k_dec;
                end
            end
            B_A_DONE:
            begin
                m_we      = 1'b1;
                m_wdata   = {1'b0, 1'b1, k_reg};
                fc_next   = fc_reg - blk_bytes;
                done_next = 1'b1;
                addr_next = addr_wide[ADDR_W-1:0];
                stat_next = STATUS_OK;
            end
            B_F_CHK:
            begin
                if (m_rdata[MW-2])
                begin
                    k_next  = m_rdata[ORD_W-1:0];
                    fc_next = fc_reg + FC_W'(64'(MIN_BLOCK_BYTES) << m_rdata[ORD_W-1:0]);
                    m_we    = 1'b1;
                    m_wdata = {1'b0, 1'b0, m_rdata[ORD_W-1:0]};
                end
                else
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    stat_next = STATUS_BAD_FREE;
                end
            end
            B_M_RD:
            begin
                b_next = buddy;
            end
            B_M_CHK:
            begin
                if (buddy_free)
                begin
                    cur_next       = head_reg[k_reg];
                    first_next     = 1'b1;
                    ret_alloc_next = 1'b0;
                end
            end
            B_PUSH:
            begin
                n_we      = 1'b1;
                head_next[k_reg] = s_reg;
                len_next[k_reg]  = len_reg[k_reg] + LEN_W'(1);
                m_we      = 1'b1;
                m_wdata   = {1'b1, 1'b0, k_reg};
                done_next = 1'b1;
                addr_next = '0;
                stat_next = STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign clearing    = st_reg == B_CLEAR;
    assign done        = done_reg;
    assign result_addr = addr_reg;
    assign status      = stat_reg;
    assign fc_wide     = 64'(fc_reg);
    assign free_bytes  = fc_wide[FREE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_CLEAR;
            clr_reg  <= '0;
            fc_reg   <= FC_W'(64'(MIN_BLOCK_BYTES) << TOP_ORDER);
            done_reg <= 1'b0;
            for (int i = 0; i < ORDERS; i++)
            begin
                head_reg[i] <= '0;
                len_reg[i]  <= (i == TOP_ORDER) ? LEN_W'(1) : '0;
            end
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            fc_reg   <= fc_next;
            done_reg <= done_next;
            head_reg <= head_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        b_reg         <= b_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        k_reg         <= k_next;
        kmin_reg      <= kmin_next;
        first_reg     <= first_next;
        ret_alloc_reg <= ret_alloc_next;
        addr_reg      <= addr_next;
        stat_reg      <= stat_next;
    end

endmodule

`default_nettype wire

FILE: rtl/buddy_block_allocator.sv
// Buddy block allocator. One result per transaction, strobed on done for one cycle.
// Flow: front end, queue, back end; the back end allocates by unlinking a block and
// splitting it, or frees by merging with each free buddy (unlinking it from its list)
// and pushing the block; a rejected transaction is answered after it leaves the queue.
// Throughput: one transaction at a time in the back end; the list walks set the rate.
// Reset: asynchronous; then a clearing pass writes all HEAP_BYTES/MIN_BLOCK_BYTES slot
// flags (2048 by default) while busy stays high. done cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator import bba_pkg::*; #(
    parameter int HEAP_BYTES      = 1048576,
    parameter int MIN_BLOCK_BYTES = 512,
    parameter int HEADER_BYTES    = 24,
    parameter int ALIGN_BYTES     = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire                   req_type,
    input  wire  [REQ_SIZE_W-1:0] req_size,
    input  wire  [ADDR_W-1:0]     block_addr,
    output logic                  done,
    output logic [ADDR_W-1:0]     result_addr,
    output logic [STATUS_W-1:0]   status,
    output logic [FREE_W-1:0]     free_bytes
);

    localparam int NUM_SLOTS = HEAP_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int TOP_ORDER = $clog2(NUM_SLOTS + 1) - 1;
    localparam int ORDERS    = TOP_ORDER + 1;
    localparam int ORD_W     = ORDERS > 1 ? $clog2(ORDERS) : 1;
    localparam int ITEM_W    = 2 + ORD_W + SLOT_W;

    logic              clearing;
    logic              push;
    logic [ITEM_W-1:0] front_item;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;
    logic [ITEM_W-1:0] q_item;

    // Front end: register the transaction, round the size or decode the
    // address, and hand a classified item onward.
    bba_front #(
        .HEAP_BYTES      (HEAP_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .ALIGN_BYTES     (ALIGN_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .clearing   (clearing),
        .req_type   (req_type),
        .req_size   (req_size),
        .block_addr (block_addr),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .item       (front_item)
    );

    // Hold classified items so the front end can keep accepting while the
    // back end walks its lists, until both queue entries are full.
    bba_queue #(.WIDTH(ITEM_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .pop   (q_pop),
        .valid (q_valid),
        .full  (q_full),
        .rdata (q_item)
    );

    // Back end: order lists, split and merge, result.
    bba_back #(
        .HEAP_BYTES      (HEAP_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .free_bytes  (free_bytes)
    );

endmodule

`default_nettype wire
